@@ design/sfr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the stuffed frame receiver
// Line byte codes, frame phases, result kinds and the structs that pass
// between the unstuffer, the frame parser and the output register.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam logic [7:0] FLAG_BYTE   = 8'h7E;
    localparam logic [7:0] ESCAPE_BYTE = 8'h7D;
    localparam logic [7:0] ESCAPE_MASK = 8'h20;
    localparam logic [7:0] ZERO_BYTE   = 8'h00;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_TRAILER = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD     = 2'd2
    } kind_t;

    // One line byte after unstuffing.
    typedef struct packed {
        logic       start;
        logic       data_valid;
        logic [7:0] data;
    } symbol_t;

    // One result item as it leaves the parser.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload_byte;
        logic [7:0] frame_address;
        logic [7:0] frame_code;
        logic [3:0] frame_length;
        logic [3:0] frame_flags;
    } result_t;

endpackage : sfr_pkg
`default_nettype wire

@@ design/sfr_unstuff.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_unstuff: byte unstuffer
// Detects the flag byte, tracks escapes and returns the unescaped data byte.
// ----------------------------------------------------------------------------
module sfr_unstuff (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire logic [7:0]       line_byte,
    output sfr_pkg::symbol_t      symbol
);
    import sfr_pkg::*;

    logic escape_pending_reg;
    logic escape_pending_next;

    always_comb
    begin
        symbol.start        = 1'b0;
        symbol.data_valid   = 1'b0;
        symbol.data         = line_byte;
        escape_pending_next = escape_pending_reg;
        priority if (line_byte == FLAG_BYTE)
        begin
            // A flag always restarts, even right after an escape.
            symbol.start        = 1'b1;
            escape_pending_next = 1'b0;
        end
        else if (escape_pending_reg)
        begin
            symbol.data_valid   = 1'b1;
            symbol.data         = line_byte ^ ESCAPE_MASK;
            escape_pending_next = 1'b0;
        end
        else if (line_byte == ESCAPE_BYTE)
        begin
            escape_pending_next = 1'b1;
        end
        else
        begin
            symbol.data_valid = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_pending_reg <= 1'b0;
        end
        else if (advance)
        begin
            escape_pending_reg <= escape_pending_next;
        end
    end

    a_flag_clears_escape: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && line_byte == FLAG_BYTE) |=> !escape_pending_reg)
        else $error("escape still pending after a flag byte");

endmodule : sfr_unstuff
`default_nettype wire

@@ design/sfr_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_parser: frame parser
// Gathers the header, passes payload bytes out, sums header and payload
// and checks the trailer against that sum; a zero trailer also passes.
// ----------------------------------------------------------------------------
module sfr_parser (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  sfr_pkg::symbol_t      symbol,
    output logic                  result_valid,
    output sfr_pkg::result_t      result
);
    import sfr_pkg::*;

    phase_t      phase_reg,         phase_next;
    logic [1:0]  field_index_reg,   field_index_next;
    logic [3:0]  hdr_length_reg,    hdr_length_next;
    logic [3:0]  hdr_flags_reg,     hdr_flags_next;
    logic [7:0]  hdr_address_reg,   hdr_address_next;
    logic [7:0]  hdr_code_reg,      hdr_code_next;
    logic [3:0]  payload_count_reg, payload_count_next;
    logic [15:0] running_sum_reg,   running_sum_next;
    logic [7:0]  trailer_high_reg,  trailer_high_next;

    logic [15:0] sum_plus_byte;
    logic [15:0] trailer_word;
    logic [3:0]  count_inc;

    assign sum_plus_byte = running_sum_reg + {8'h00, symbol.data};
    assign trailer_word  = {trailer_high_reg, symbol.data};
    assign count_inc     = payload_count_reg + 4'd1;

    always_comb
    begin
        phase_next         = phase_reg;
        field_index_next   = field_index_reg;
        hdr_length_next    = hdr_length_reg;
        hdr_flags_next     = hdr_flags_reg;
        hdr_address_next   = hdr_address_reg;
        hdr_code_next      = hdr_code_reg;
        payload_count_next = payload_count_reg;
        running_sum_next   = running_sum_reg;
        trailer_high_next  = trailer_high_reg;
        result_valid       = 1'b0;
        result.kind        = KIND_PAYLOAD;
        result.payload_byte = ZERO_BYTE;

        if (symbol.start)
        begin
            running_sum_next   = 16'h0000;
            field_index_next   = 2'd0;
            payload_count_next = 4'd0;
            phase_next         = PH_HEADER;
        end
        else if (symbol.data_valid)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    // Junk between frames is dropped.
                end
                PH_HEADER:
                begin
                    running_sum_next = sum_plus_byte;
                    priority case (field_index_reg)
                        2'd0:
                        begin
                            hdr_length_next  = symbol.data[7:4];
                            hdr_flags_next   = symbol.data[3:0];
                            field_index_next = 2'd1;
                        end
                        2'd1:
                        begin
                            hdr_address_next = symbol.data;
                            field_index_next = 2'd2;
                        end
                        default:
                        begin
                            hdr_code_next      = symbol.data;
                            field_index_next   = 2'd0;
                            payload_count_next = 4'd0;
                            phase_next = (hdr_length_reg != 4'd0) ? PH_PAYLOAD : PH_TRAILER;
                        end
                    endcase
                end
                PH_PAYLOAD:
                begin
                    running_sum_next    = sum_plus_byte;
                    payload_count_next  = count_inc;
                    if (count_inc == hdr_length_reg)
                    begin
                        phase_next       = PH_TRAILER;
                        field_index_next = 2'd0;
                    end
                    result_valid        = 1'b1;
                    result.kind         = KIND_PAYLOAD;
                    result.payload_byte = symbol.data;
                end
                PH_TRAILER:
                begin
                    if (field_index_reg == 2'd0)
                    begin
                        trailer_high_next = symbol.data;
                        field_index_next  = 2'd1;
                    end
                    else
                    begin
                        field_index_next = 2'd0;
                        phase_next       = PH_HUNT;
                        result_valid     = 1'b1;
                        result.kind = (trailer_word == 16'h0000 ||
                                       trailer_word == running_sum_reg) ? KIND_GOOD : KIND_BAD;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Header fields in a result are those after this byte is taken.
        result.frame_address = hdr_address_next;
        result.frame_code    = hdr_code_next;
        result.frame_length  = hdr_length_next;
        result.frame_flags   = hdr_flags_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HUNT;
            field_index_reg   <= 2'd0;
            hdr_length_reg    <= 4'd0;
            hdr_flags_reg     <= 4'd0;
            hdr_address_reg   <= 8'h00;
            hdr_code_reg      <= 8'h00;
            payload_count_reg <= 4'd0;
            running_sum_reg   <= 16'h0000;
            trailer_high_reg  <= 8'h00;
        end
        else if (advance)
        begin
            phase_reg         <= phase_next;
            field_index_reg   <= field_index_next;
            hdr_length_reg    <= hdr_length_next;
            hdr_flags_reg     <= hdr_flags_next;
            hdr_address_reg   <= hdr_address_next;
            hdr_code_reg      <= hdr_code_next;
            payload_count_reg <= payload_count_next;
            running_sum_reg   <= running_sum_next;
            trailer_high_reg  <= trailer_high_next;
        end
    end

    a_payload_needs_length: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (payload_count_reg < hdr_length_reg))
        else $error("payload phase with count at or past the header length");

    a_header_index: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEADER) |-> (field_index_reg != 2'd3))
        else $error("header byte index out of range");

    a_trailer_index: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TRAILER || phase_reg == PH_HUNT) |-> (field_index_reg[1] == 1'b0))
        else $error("trailer byte index out of range");

endmodule : sfr_parser
`default_nettype wire

@@ design/sfr_out_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_out_reg: result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module sfr_out_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  sfr_pkg::result_t      result_in,
    input  wire logic             out_ready,
    output logic                  out_valid,
    output sfr_pkg::result_t      result_out
);
    import sfr_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = data_reg;

endmodule : sfr_out_reg
`default_nettype wire

@@ design/stuffed_frame_receiver.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Path: each line byte is held in the input register, and its result, if any,
// then goes into the result register before it is handed downstream.
// Throughput: one line byte per cycle; the input register and the result
// register keep both sides moving, so only a stalled result holds the input.
// Reset (rst_n low, asynchronous) returns to the hunt for a start flag,
// clears the header, sum and escape state and empties both registers.
// ----------------------------------------------------------------------------
// stuffed_frame_receiver: byte-stuffed frame receiver
// Unstuffs line bytes, parses header, payload and trailer, and returns
// payload bytes and a good or bad status at the end of each complete frame.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      kind,
    output logic [7:0]      payload_byte,
    output logic [7:0]      frame_address,
    output logic [7:0]      frame_code,
    output logic [3:0]      frame_length,
    output logic [3:0]      frame_flags
);
    import sfr_pkg::*;

    logic       in_full_reg;
    logic [7:0] in_byte_reg;
    logic       advance;
    logic       out_free;
    logic       result_valid;
    symbol_t    symbol;
    result_t    result;
    result_t    result_q;

    // The held byte moves on when the result register can take a result.
    assign out_free = !out_valid || out_ready;
    assign advance  = in_full_reg && out_free;
    assign in_ready = !in_full_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_full_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    sfr_unstuff u_unstuff (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .line_byte (in_byte_reg),
        .symbol    (symbol)
    );

    sfr_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .symbol       (symbol),
        .result_valid (result_valid),
        .result       (result)
    );

    sfr_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && result_valid),
        .result_in  (result),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .result_out (result_q)
    );

    assign kind          = result_q.kind;
    assign payload_byte  = result_q.payload_byte;
    assign frame_address = result_q.frame_address;
    assign frame_code    = result_q.frame_code;
    assign frame_length  = result_q.frame_length;
    assign frame_flags   = result_q.frame_flags;

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_full_reg && out_valid && !out_ready) |=> (in_full_reg && $stable(in_byte_reg)))
        else $error("held line byte lost while the result is stalled");

endmodule : stuffed_frame_receiver
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking regression for stuffed_frame_receiver
// Feeds escaped line bytes (hand-picked corner frames, then random frames,
// cut-off frames and line noise) through the valid/ready input. The expected
// payload bytes and frame verdicts are worked out alongside, and every
// returned result is checked in order.
// ----------------------------------------------------------------------------
module testbench;

    import sfr_pkg::*;

    localparam int FRAME_BYTE_GOAL = 1850;
    localparam int TAIL_BYTES      = 150;
    localparam int HOLDOFF_CYCLES  = 300;
    localparam int DRAIN_CYCLES    = 10;

    localparam logic [7:0] ESCAPED_FLAG   = FLAG_BYTE ^ ESCAPE_MASK;
    localparam logic [7:0] ESCAPED_ESCAPE = ESCAPE_BYTE ^ ESCAPE_MASK;

    // Corner frames: escapes in the hunt, escaped escape and flag values as
    // data, a zero trailer, a zero-length frame with a wrong trailer, and a
    // start flag straight after an escape.
    localparam logic [7:0] OPENING_BYTES [26] = '{
        ESCAPE_BYTE, ESCAPED_FLAG,
        FLAG_BYTE, 8'h10, ESCAPE_BYTE, ESCAPED_ESCAPE, ESCAPE_BYTE, ESCAPE_BYTE,
        ESCAPE_BYTE, ESCAPED_FLAG, ZERO_BYTE, ZERO_BYTE,
        FLAG_BYTE, 8'h0F, 8'hFF, ZERO_BYTE, 8'hFF, 8'hFF,
        FLAG_BYTE, ESCAPE_BYTE, FLAG_BYTE, 8'h03, 8'hAA, 8'h55, 8'h01, 8'h02
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [7:0] frame_address;
    logic [7:0] frame_code;
    logic [3:0] frame_length;
    logic [3:0] frame_flags;

    stuffed_frame_receiver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .payload_byte  (payload_byte),
        .frame_address (frame_address),
        .frame_code    (frame_code),
        .frame_length  (frame_length),
        .frame_flags   (frame_flags)
    );

    // Line bytes waiting to be sent and the deframed results still owed.
    logic [7:0] line_bytes [$];
    logic [7:0] frame_buf [$];
    result_t    deframed_results [$];

    // Deframer state as the line bytes are taken.
    phase_t      rx_phase = PH_HUNT;
    logic        esc_armed = 1'b0;
    logic [1:0]  hdr_pos = 2'd0;
    logic [3:0]  cur_length = 4'd0;
    logic [3:0]  cur_flags = 4'd0;
    logic [7:0]  cur_address = 8'd0;
    logic [7:0]  cur_code = 8'd0;
    logic [3:0]  pay_seen = 4'd0;
    logic [15:0] frame_sum = 16'd0;
    logic [7:0]  trail_high = 8'd0;

    int   frame_items = 0;
    int   bytes_taken = 0;
    int   results_seen = 0;
    int   payload_checked = 0;
    int   frames_good = 0;
    int   frames_bad = 0;
    int   mismatches = 0;
    int   src_idle = 0;
    int   src_idle_pct = 0;
    int   sink_idle = 0;
    int   sink_stall_pct = 0;
    logic calm_tail = 1'b0;
    logic sink_hold = 1'b0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] mismatch on %0s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic owe_result(input kind_t k, input logic [7:0] b);
        result_t r;
        r.kind          = k;
        r.payload_byte  = b;
        r.frame_address = cur_address;
        r.frame_code    = cur_code;
        r.frame_length  = cur_length;
        r.frame_flags   = cur_flags;
        deframed_results.push_back(r);
    endtask

    task automatic absorb_line_byte(input logic [7:0] raw);
        logic [7:0]  b;
        logic [15:0] trailer;
        b = raw;
        // A start flag wins over everything, even a pending escape.
        if (b == FLAG_BYTE)
        begin
            frame_sum = 16'd0;
            esc_armed = 1'b0;
            hdr_pos   = 2'd0;
            pay_seen  = 4'd0;
            rx_phase  = PH_HEADER;
            return;
        end
        if (esc_armed)
        begin
            b = b ^ ESCAPE_MASK;
            esc_armed = 1'b0;
        end
        else if (b == ESCAPE_BYTE)
        begin
            esc_armed = 1'b1;
            return;
        end
        case (rx_phase)
            PH_HEADER:
            begin
                frame_sum = frame_sum + b;
                if (hdr_pos == 2'd0)
                begin
                    cur_length = b[7:4];
                    cur_flags  = b[3:0];
                    hdr_pos    = 2'd1;
                end
                else if (hdr_pos == 2'd1)
                begin
                    cur_address = b;
                    hdr_pos     = 2'd2;
                end
                else
                begin
                    cur_code = b;
                    hdr_pos  = 2'd0;
                    pay_seen = 4'd0;
                    rx_phase = (cur_length != 4'd0) ? PH_PAYLOAD : PH_TRAILER;
                end
            end
            PH_PAYLOAD:
            begin
                frame_sum = frame_sum + b;
                pay_seen  = pay_seen + 4'd1;
                if (pay_seen == cur_length)
                begin
                    rx_phase = PH_TRAILER;
                    hdr_pos  = 2'd0;
                end
                owe_result(KIND_PAYLOAD, b);
            end
            PH_TRAILER:
            begin
                if (hdr_pos == 2'd0)
                begin
                    trail_high = b;
                    hdr_pos    = 2'd1;
                end
                else
                begin
                    trailer  = {trail_high, b};
                    hdr_pos  = 2'd0;
                    rx_phase = PH_HUNT;
                    if (trailer == 16'd0 || trailer == frame_sum)
                        owe_result(KIND_GOOD, ZERO_BYTE);
                    else
                        owe_result(KIND_BAD, ZERO_BYTE);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Biased toward the flag and escape values and the byte extremes.
    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0)
        begin
            case ($urandom_range(0, 5))
                0: b = FLAG_BYTE;
                1: b = ESCAPE_BYTE;
                2: b = ESCAPED_FLAG;
                3: b = ESCAPED_ESCAPE;
                4: b = ZERO_BYTE;
                default: b = 8'hFF;
            endcase
        end
        return b;
    endfunction

    // Stuffs one byte; ordinary bytes are now and then escaped as well,
    // except where the escaped form would look like a start flag.
    task automatic stuff_byte(input logic [7:0] b);
        if (b == FLAG_BYTE || b == ESCAPE_BYTE ||
            ((b ^ ESCAPE_MASK) != FLAG_BYTE && $urandom_range(0, 15) == 0))
        begin
            frame_buf.push_back(ESCAPE_BYTE);
            frame_buf.push_back(b ^ ESCAPE_MASK);
        end
        else
            frame_buf.push_back(b);
    endtask

    task automatic queue_frame(input logic cut_short);
        logic [7:0]  body [$];
        logic [15:0] sum;
        logic [15:0] trailer;
        int          n;
        body.delete();
        body.push_back(pick_byte());
        body.push_back(pick_byte());
        body.push_back(pick_byte());
        for (n = 0; n < int'(body[0][7:4]); n++)
            body.push_back(pick_byte());
        sum = 16'd0;
        foreach (body[i])
            sum = sum + body[i];
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: trailer = sum;
            5, 6: trailer = 16'd0;
            default: trailer = 16'($urandom_range(0, 65535));
        endcase
        frame_buf.delete();
        frame_buf.push_back(FLAG_BYTE);
        foreach (body[i])
            stuff_byte(body[i]);
        stuff_byte(trailer[15:8]);
        stuff_byte(trailer[7:0]);
        if (cut_short)
        begin
            n = $urandom_range(1, frame_buf.size() - 1);
            while (frame_buf.size() > n)
                void'(frame_buf.pop_back());
            if ($urandom_range(0, 2) == 0)
                frame_buf.push_back(ESCAPE_BYTE);
        end
        frame_items += frame_buf.size();
        foreach (frame_buf[i])
            line_bytes.push_back(frame_buf[i]);
    endtask

    task automatic queue_noise();
        int n;
        n = $urandom_range(1, 6);
        frame_items += n;
        repeat (n)
            line_bytes.push_back(pick_byte());
    endtask

    always @(posedge clk)
    begin : line_driver
        logic holding;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                absorb_line_byte(rx_byte);
                bytes_taken <= bytes_taken + 1;
                if (bytes_taken % 64 == 0)
                begin
                    case ($urandom_range(0, 2))
                        0: src_idle_pct = 0;
                        1: src_idle_pct = 10;
                        default: src_idle_pct = 40;
                    endcase
                end
            end
            holding = in_valid && !in_ready;
            calm_tail <= (line_bytes.size() < TAIL_BYTES);
            if (!holding)
            begin
                if (src_idle > 0)
                begin
                    src_idle--;
                    in_valid <= 1'b0;
                end
                else if (line_bytes.size() == 0)
                    in_valid <= 1'b0;
                else if (line_bytes.size() >= TAIL_BYTES &&
                         $urandom_range(0, 99) < src_idle_pct)
                begin
                    src_idle = $urandom_range(0, 10);
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= line_bytes.pop_front();
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (deframed_results.size() == 0)
                    report_mismatch("unexpected result kind", int'(kind), -1);
                else
                begin
                    want = deframed_results.pop_front();
                    if (kind !== want.kind)
                        report_mismatch("kind", int'(kind), int'(want.kind));
                    if (payload_byte !== want.payload_byte)
                        report_mismatch("payload_byte", int'(payload_byte),
                                        int'(want.payload_byte));
                    if (frame_address !== want.frame_address)
                        report_mismatch("frame_address", int'(frame_address),
                                        int'(want.frame_address));
                    if (frame_code !== want.frame_code)
                        report_mismatch("frame_code", int'(frame_code),
                                        int'(want.frame_code));
                    if (frame_length !== want.frame_length)
                        report_mismatch("frame_length", int'(frame_length),
                                        int'(want.frame_length));
                    if (frame_flags !== want.frame_flags)
                        report_mismatch("frame_flags", int'(frame_flags),
                                        int'(want.frame_flags));
                    case (want.kind)
                        KIND_PAYLOAD: payload_checked++;
                        KIND_GOOD: frames_good++;
                        default: frames_bad++;
                    endcase
                end
                results_seen++;
                if (results_seen % 50 == 0)
                begin
                    case ($urandom_range(0, 2))
                        0: sink_stall_pct = 0;
                        1: sink_stall_pct = 15;
                        default: sink_stall_pct = 45;
                    endcase
                end
            end
            if (sink_hold)
                out_ready <= 1'b0;
            else if (sink_idle > 0)
            begin
                sink_idle--;
                out_ready <= 1'b0;
            end
            else if (!calm_tail && $urandom_range(0, 99) < sink_stall_pct)
            begin
                sink_idle = $urandom_range(0, 10);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // One long receiver hold-off so the block backs up and stalls its input.
    initial
    begin : sink_holdoff
        int n;
        while (bytes_taken < 400)
            @(posedge clk);
        sink_hold <= 1'b1;
        for (n = 0; n < HOLDOFF_CYCLES; n++)
            @(posedge clk);
        sink_hold <= 1'b0;
    end

    initial
    begin : watchdog
        #2000000;
        $display("stuffed_frame_receiver regression: fail");
        $finish;
    end

    initial
    begin : stimulus_and_wrapup
        int pick;
        foreach (OPENING_BYTES[i])
            line_bytes.push_back(OPENING_BYTES[i]);
        frame_items = $size(OPENING_BYTES);
        while (frame_items < FRAME_BYTE_GOAL)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
                queue_frame(1'b0);
            else if (pick < 88)
                queue_frame(1'b1);
            else
                queue_noise();
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (line_bytes.size() != 0 || in_valid || deframed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (deframed_results.size() != 0)
            report_mismatch("results never returned", 0, deframed_results.size());
        $display("Sent %0d line bytes; checked %0d payload bytes, %0d good and %0d bad frames.",
                 bytes_taken, payload_checked, frames_good, frames_bad);
        $display("Result mismatches: %0d.", mismatches);
        if (mismatches == 0)
            $display("stuffed_frame_receiver regression: pass");
        else
            $display("stuffed_frame_receiver regression: fail");
        $finish;
    end

endmodule
